FILE: design/integer_to_ascii_formatter_core_assert.svh
// Assertion macros used by the formatter core.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define ITOA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("formatter assertion failed");

// Next-cycle implication.
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("formatter assertion failed");

`endif

FILE: design/itoa_fmt_pkg.sv
// Types, codes and character helpers for the integer to ASCII formatter.
`default_nettype none

package itoa_fmt_pkg;

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] value;
      logic [15:0] start_count;
   } req_type;

   typedef struct packed {
      logic [7:0]  character;
      logic [15:0] running_count;
      logic        last;
   } rsp_type;

   localparam logic [2:0] ACT_SDEC = 3'd0;
   localparam logic [2:0] ACT_UDEC = 3'd1;
   localparam logic [2:0] ACT_HEXL = 3'd2;
   localparam logic [2:0] ACT_HEXU = 3'd3;
   localparam logic [2:0] ACT_PTR  = 3'd4;

   localparam logic [1:0] PFX_NONE  = 2'd0;
   localparam logic [1:0] PFX_MINUS = 2'd1;
   localparam logic [1:0] PFX_HEX   = 2'd2;
   localparam logic [1:0] PFX_NIL   = 2'd3;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   function automatic logic [2:0] pfx_len(input logic [1:0] kind);
      logic [2:0] len;
      case (kind)
         PFX_MINUS: len = 3'd1;
         PFX_HEX:   len = 3'd2;
         PFX_NIL:   len = 3'd5;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] pfx_char(input logic [1:0] kind, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h3F;
      case (kind)
         PFX_MINUS: ch = 8'h2D;
         PFX_HEX:   ch = (idx == 3'd0) ? 8'h30 : 8'h78;
         PFX_NIL: begin
            case (idx)
               3'd0:    ch = 8'h28;
               3'd1:    ch = 8'h6E;
               3'd2:    ch = 8'h69;
               3'd3:    ch = 8'h6C;
               default: ch = 8'h29;
            endcase
         end
         default:   ch = 8'h3F;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] dig, input logic upper);
      logic [7:0] ch;
      if (dig < 4'd10) begin
         ch = 8'h30 + {4'd0, dig};
      end else if (upper) begin
         ch = 8'h37 + {4'd0, dig};
      end else begin
         ch = 8'h57 + {4'd0, dig};
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

FILE: design/integer_to_ascii_formatter_core.sv
// Integer to ASCII formatter: decimal, hex and pointer text, one character per response.
//
//   channel | dir | payload                                 | handshake
//   req     | in  | action, value, start_count              | req_valid / req_ready
//   rsp     | out | character, running_count, last          | rsp_valid / rsp_ready
//
// Decimal: accept, 32 double-dabble steps, up to 9 leading-zero skips, a hand-off, then
//   the characters, at most 11 ("-2147483648"), or 10 for unsigned.
// Hex: accept, leading-zero skips, a hand-off, then the characters; "(nil)" goes straight to its characters.
// req_ready is high only between requests; responses stall freely on rsp_ready.
// Unused actions are accepted and produce no response.
// Reset is synchronous and clears control state only.
`default_nettype none

`include "integer_to_ascii_formatter_core_assert.svh"

module integer_to_ascii_formatter_core #(
   parameter int unsigned POINTER_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire itoa_fmt_pkg::req_type req_payload,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      itoa_fmt_pkg::rsp_type rsp_payload
);

   localparam logic [63:0] PtrMask = {64{1'b1}} >> (64 - POINTER_BITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_PFX  = 3'd3;
   localparam logic [2:0] ST_DIG  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [63:0] dig_ff, dig_in;
   logic [31:0] bin_ff, bin_in;
   logic [4:0]  step_ff, step_in;
   logic [4:0]  ndig_ff, ndig_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic        upper_ff, upper_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   itoa_fmt_pkg::rsp_type rsp_ff, rsp_in;

   logic [39:0] bcd_adj;
   logic [31:0] mag32;
   logic [63:0] ptr_val;
   logic        emit_ok;
   logic        emit_go;
   logic        emit_last;
   logic [7:0]  emit_char;
   logic [15:0] cnt_next;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign emit_ok  = !rsp_valid_ff || rsp_ready;
   assign cnt_next = (cnt_ff == itoa_fmt_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 16'd1;
   assign mag32    = req_payload.value[31] ? (~req_payload.value[31:0] + 32'd1)
                                           : req_payload.value[31:0];
   assign ptr_val  = req_payload.value & PtrMask;

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         bcd_adj[4*i +: 4] = (dig_ff[24 + 4*i +: 4] >= 4'd5) ? dig_ff[24 + 4*i +: 4] + 4'd3
                                                             : dig_ff[24 + 4*i +: 4];
      end
   end

   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      bin_in    = bin_ff;
      step_in   = step_ff;
      ndig_in   = ndig_ff;
      kind_in   = kind_ff;
      pidx_in   = pidx_ff;
      upper_in  = upper_ff;
      cnt_in    = cnt_ff;
      emit_go   = 1'b0;
      emit_last = 1'b0;
      emit_char = 8'h00;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in   = req_payload.start_count;
               pidx_in  = 3'd0;
               step_in  = 5'd0;
               upper_in = 1'b0;
               kind_in  = itoa_fmt_pkg::PFX_NONE;
               case (req_payload.action)
                  itoa_fmt_pkg::ACT_SDEC: begin
                     bin_in   = mag32;
                     dig_in   = 64'd0;
                     ndig_in  = 5'd10;
                     kind_in  = req_payload.value[31] ? itoa_fmt_pkg::PFX_MINUS
                                                      : itoa_fmt_pkg::PFX_NONE;
                     state_in = ST_CONV;
                  end
                  itoa_fmt_pkg::ACT_UDEC: begin
                     bin_in   = req_payload.value[31:0];
                     dig_in   = 64'd0;
                     ndig_in  = 5'd10;
                     state_in = ST_CONV;
                  end
                  itoa_fmt_pkg::ACT_HEXL, itoa_fmt_pkg::ACT_HEXU: begin
                     dig_in   = {req_payload.value[31:0], 32'd0};
                     ndig_in  = 5'd8;
                     upper_in = (req_payload.action == itoa_fmt_pkg::ACT_HEXU);
                     state_in = ST_SKIP;
                  end
                  itoa_fmt_pkg::ACT_PTR: begin
                     dig_in  = ptr_val;
                     ndig_in = 5'd16;
                     if (ptr_val == 64'd0) begin
                        kind_in  = itoa_fmt_pkg::PFX_NIL;
                        state_in = ST_PFX;
                     end else begin
                        kind_in  = itoa_fmt_pkg::PFX_HEX;
                        state_in = ST_SKIP;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            dig_in[63:24] = {bcd_adj[38:0], bin_ff[31]};
            bin_in        = {bin_ff[30:0], 1'b0};
            step_in       = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((dig_ff[63:60] == 4'd0) && (ndig_ff > 5'd1)) begin
               dig_in  = {dig_ff[59:0], 4'd0};
               ndig_in = ndig_ff - 5'd1;
            end else begin
               state_in = (itoa_fmt_pkg::pfx_len(kind_ff) == 3'd0) ? ST_DIG : ST_PFX;
            end
         end
         ST_PFX: begin
            if (emit_ok) begin
               emit_go   = 1'b1;
               emit_char = itoa_fmt_pkg::pfx_char(kind_ff, pidx_ff);
               emit_last = (kind_ff == itoa_fmt_pkg::PFX_NIL) && (pidx_ff == 3'd4);
               cnt_in    = cnt_next;
               pidx_in   = pidx_ff + 3'd1;
               if (pidx_ff + 3'd1 == itoa_fmt_pkg::pfx_len(kind_ff)) begin
                  state_in = (kind_ff == itoa_fmt_pkg::PFX_NIL) ? ST_IDLE : ST_DIG;
               end
            end
         end
         ST_DIG: begin
            if (emit_ok) begin
               emit_go   = 1'b1;
               emit_char = itoa_fmt_pkg::digit_char(dig_ff[63:60], upper_ff);
               emit_last = (ndig_ff == 5'd1);
               cnt_in    = cnt_next;
               dig_in    = {dig_ff[59:0], 4'd0};
               ndig_in   = ndig_ff - 5'd1;
               if (ndig_ff == 5'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_go) begin
         rsp_in.character     = emit_char;
         rsp_in.running_count = cnt_next;
         rsp_in.last          = emit_last;
         rsp_valid_in         = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 5'd0;
         ndig_ff      <= 5'd0;
         pidx_ff      <= 3'd0;
         kind_ff      <= itoa_fmt_pkg::PFX_NONE;
         cnt_ff       <= 16'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         ndig_ff      <= ndig_in;
         pidx_ff      <= pidx_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff   <= dig_in;
      bin_ff   <= bin_in;
      upper_ff <= upper_in;
      rsp_ff   <= rsp_in;
   end

   `ITOA_ASSERT_NEXT(a_conv_done, clock, reset,
      (state_ff == ST_CONV) && (step_ff == 5'd31), state_ff == ST_SKIP)
   `ITOA_ASSERT_NOW(a_dig_range, clock, reset,
      state_ff == ST_DIG, (ndig_ff != 5'd0) && (ndig_ff <= 5'd16))
   `ITOA_ASSERT_NEXT(a_last_idle, clock, reset, emit_go && emit_last, state_ff == ST_IDLE)
   `ITOA_ASSERT_NEXT(a_cnt_load, clock, reset,
      req_valid && req_ready, cnt_ff == $past(req_payload.start_count))

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the integer to ASCII formatter core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POINTER_BITS = 64;
   localparam logic [63:0] POINTER_MASK =
      (POINTER_BITS >= 64) ? '1 : (64'd1 << POINTER_BITS) - 64'd1;

   // actions the block accepts and drops
   localparam logic [2:0] ACT_SPARE5 = 3'd5;
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;

   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_REQUESTS = 140;
   localparam int MAX_GAP         = 17;
   localparam int LONG_HOLD       = 300;
   localparam int HOLD_AT         = 60;
   localparam int DRAIN_CYCLES    = 64;
   localparam int STALL_LIMIT     = 2000;

   typedef byte unsigned text_type[$];

   typedef struct {
      itoa_fmt_pkg::req_type req;
      bit                    typed;
      string                 text;
   } stim_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   itoa_fmt_pkg::req_type req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   itoa_fmt_pkg::rsp_type rsp_payload;

   itoa_fmt_pkg::rsp_type expected_chars[$];
   int      failures     = 0;
   int      results_seen = 0;
   int      stall_cycles = 0;
   bit      sender_gaps  = 1'b1;

   integer_to_ascii_formatter_core #(
      .POINTER_BITS(POINTER_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic text_type text_of(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   // Characters the block should emit for one request.
   function automatic text_type format_request(input itoa_fmt_pkg::req_type r);
      text_type    t;
      text_type    digits;
      logic [63:0] mag;
      logic [63:0] base;
      logic [31:0] low;
      string       glyphs;
      string       prefix;
      bit          numeric;
      glyphs  = "0123456789abcdef";
      prefix  = "";
      numeric = 1'b1;
      base    = 64'd16;
      low     = r.value[31:0];
      mag     = {32'd0, low};
      case (r.action)
         itoa_fmt_pkg::ACT_SDEC: begin
            base = 64'd10;
            if (low[31]) begin
               prefix = "-";
               mag    = {32'd0, -low};
            end
         end
         itoa_fmt_pkg::ACT_UDEC: base = 64'd10;
         itoa_fmt_pkg::ACT_HEXL: ;
         itoa_fmt_pkg::ACT_HEXU: glyphs = "0123456789ABCDEF";
         itoa_fmt_pkg::ACT_PTR: begin
            mag = r.value & POINTER_MASK;
            if (mag == 64'd0) begin
               prefix  = "(nil)";
               numeric = 1'b0;
            end else begin
               prefix = "0x";
            end
         end
         default: numeric = 1'b0;
      endcase
      t = text_of(prefix);
      if (numeric) begin
         do begin
            digits.push_front(glyphs[int'(mag % base)]);
            mag = mag / base;
         end while (mag != 64'd0);
         foreach (digits[i]) t.push_back(digits[i]);
      end
      return t;
   endfunction

   function automatic void queue_expected(input text_type chars, input logic [15:0] start);
      logic [15:0]           count;
      itoa_fmt_pkg::rsp_type e;
      count = start;
      foreach (chars[i]) begin
         if (count != itoa_fmt_pkg::COUNT_MAX) count = count + 16'd1;
         e.character     = chars[i];
         e.running_count = count;
         e.last          = (i == chars.size() - 1);
         expected_chars.push_back(e);
      end
   endfunction

   function automatic stim_row_type stim_row(input logic [2:0] action,
                                             input logic [63:0] value,
                                             input logic [15:0] start, input bit typed,
                                             input string text);
      stim_row_type row;
      row.req.action      = action;
      row.req.value       = value;
      row.req.start_count = start;
      row.typed           = typed;
      row.text            = text;
      return row;
   endfunction

   function automatic itoa_fmt_pkg::req_type random_request();
      itoa_fmt_pkg::req_type r;
      if ($urandom_range(0, 99) < 4) r.action = 3'($urandom_range(ACT_SPARE5, ACT_SPARE7));
      else r.action = 3'($urandom_range(itoa_fmt_pkg::ACT_SDEC, itoa_fmt_pkg::ACT_PTR));
      r.value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: r.value = r.value >> $urandom_range(0, 63);
         1: r.value = 64'($urandom_range(0, 20));
         2: r.value[31:0] = 32'd0 - 32'($urandom_range(1, 20));
         default: ;
      endcase
      if ($urandom_range(0, 4) == 0) begin
         r.start_count = 16'(itoa_fmt_pkg::COUNT_MAX - $urandom_range(0, 20));
      end else begin
         r.start_count = 16'($urandom);
      end
      return r;
   endfunction

   task automatic send_request(input itoa_fmt_pkg::req_type r, input text_type chars);
      int gap;
      if ($urandom_range(0, 19) == 0) sender_gaps = !sender_gaps;
      gap = sender_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queue_expected(chars, r.start_count);
   endtask

   initial begin
      stim_row_type          rows[$];
      text_type              chars;
      itoa_fmt_pkg::req_type r;
      int                    sent;
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, 64'd0, 16'd0, 1, "0"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, 64'h7FFF_FFFF, 16'd0, 1, "2147483647"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, 64'h8000_0000, 16'd10, 1, "-2147483648"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, '1, 16'd0, 1, "-1"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, 64'h0000_0001_0000_0000, 16'd0, 1, "0"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_UDEC, 64'hFFFF_FFFF, 16'd0, 1, "4294967295"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_UDEC, 64'd0, 16'd0, 1, "0"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_UDEC, 64'd1000000000, 16'd0, 1, "1000000000"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_HEXL, 64'hFFFF_FFFF_DEAD_BEEF, 16'd0, 1,
                              "deadbeef"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_HEXU, 64'hDEAD_BEEF, 16'd0, 1, "DEADBEEF"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_HEXL, 64'd0, 16'd0, 1, "0"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_HEXU, 64'hFFFF_FFFF, 16'd0, 1, "FFFFFFFF"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_PTR, 64'd0, 16'd0, 1, "(nil)"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_PTR, '1, 16'd0, 1, "0xffffffffffffffff"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_PTR, 64'd1, 16'd0, 1, "0x1"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_PTR, 64'h8000_0000_0000_0000, 16'd0, 1,
                              "0x8000000000000000"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_PTR, 64'h0123_4567_89AB_CDEF, 16'd0, 1,
                              "0x123456789abcdef"));
      rows.push_back(stim_row(ACT_SPARE5, '1, 16'hFFFF, 1, ""));
      rows.push_back(stim_row(ACT_SPARE6, 64'h5555_5555_5555_5555, 16'd7, 1, ""));
      rows.push_back(stim_row(ACT_SPARE7, 64'd0, 16'd0, 1, ""));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, 64'hFFFF_FFFF, 16'hFFFF, 1, "-1"));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_UDEC, 64'd12345, 16'd65530, 0, ""));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_HEXL, 64'hA0, 16'hFFFE, 0, ""));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_PTR, 64'hFFFF_0000_0000_0000, 16'hAAAA, 0,
                              ""));
      rows.push_back(stim_row(itoa_fmt_pkg::ACT_SDEC, 64'h1234_5678_8765_4321, 16'h5555, 0,
                              ""));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].typed) chars = text_of(rows[i].text);
         else chars = format_request(rows[i].req);
         send_request(rows[i].req, chars);
      end

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         r = random_request();
         if (r.action <= itoa_fmt_pkg::ACT_PTR) sent++;
         send_request(r, format_request(r));
      end
      req_valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("[integer_to_ascii_formatter_core] OK");
      end else begin
         $display("[integer_to_ascii_formatter_core] ERROR");
      end
      $finish;
   end

   // response side: random back-pressure, one long hold-off to fill the block
   initial begin
      int                    gap;
      bit                    receiver_gaps;
      itoa_fmt_pkg::rsp_type want;
      receiver_gaps = 1'b1;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) receiver_gaps = !receiver_gaps;
         gap = receiver_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (results_seen == HOLD_AT) gap = LONG_HOLD;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_seen++;
         if (expected_chars.size() == 0) begin
            failures++;
            $display("%0t unexpected response: expected none, actual %h", $time, rsp_payload);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.character != want.character) begin
               failures++;
               $display("%0t character: expected %h, actual %h",
                        $time, want.character, rsp_payload.character);
            end
            if (rsp_payload.running_count != want.running_count) begin
               failures++;
               $display("%0t running_count: expected %0d, actual %0d",
                        $time, want.running_count, rsp_payload.running_count);
            end
            if (rsp_payload.last != want.last) begin
               failures++;
               $display("%0t last: expected %b, actual %b", $time, want.last, rsp_payload.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[integer_to_ascii_formatter_core] ERROR");
         $finish;
      end
   end

endmodule
